// File: sv/apa_pkg.sv
package apa_pkg;

  localparam int ADDR_W     = 32;
  localparam int PREFIX_W   = 6;
  localparam int TOTAL_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_QUERY   = 2'd2,
    OP_RESERVE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_EXHAUSTED   = 2'd1,
    STAT_NOT_ALLOC   = 2'd2,
    STAT_OUT_WINDOW  = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 2'd1;

  localparam logic [ADDR_W-1:0]   RST_SUBNET_BASE   = 32'd0;
  localparam logic [PREFIX_W-1:0] RST_PREFIX_LENGTH = 6'd24;

  typedef struct packed {
    opcode_t             opcode;
    logic [ADDR_W-1:0]   address;
  } apa_req_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   granted_address;
    logic                is_used;
    logic [TOTAL_W-1:0]  used_total;
  } apa_rsp_t;

endpackage

// File: sv/apa_first_free.sv
module apa_first_free
  import apa_pkg::*;
#(
  parameter int SLOT_BITS = 8
) (
  input  logic [(1 << SLOT_BITS)-1:0] free_slots,
  output logic                        found,
  output logic [SLOT_BITS-1:0]        slot
);

  localparam int Slots = 1 << SLOT_BITS;

  logic [Slots-1:0] lowest;

  assign lowest = free_slots & (~free_slots + Slots'(1));
  assign found  = |free_slots;

  always_comb begin
    slot = '0;
    for (int i = 0; i < Slots; i++) begin
      slot = slot | (lowest[i] ? SLOT_BITS'(i) : '0);
    end
  end

endmodule

// File: sv/address_pool_allocator_top.sv
// Address pool allocator: first-fit address handout over one IPv4 subnet.
// Request channel: in_valid / in_stall / in_req (opcode, address).
// Response channel: out_valid / out_stall / out_rsp (status, granted_address,
// is_used, used_total). A transfer happens when valid is high and stall low.
// Configuration: cfg_we with cfg_index 0 (subnet base) or 1 (prefix length)
// and cfg_data; any such write clears the slot bitmap to the gateway only.
// Pipeline: an accepted request waits in the request register; its answer is
// loaded into the response register when that register is empty or being read.
// Throughput: one request per cycle while out_stall is low; the lowest free slot comes from a
// priority encoder over the flip-flop bitmap in the same cycle as the update.
// Reset: base 0, prefix 24, bitmap holds only the gateway slot, count one,
// both pipeline stages empty.
// Receiver stall: the response register holds; the request register holds
// behind it and in_stall rises, so no request is lost or repeated.
module address_pool_allocator_top
  import apa_pkg::*;
#(
  parameter int SLOT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  apa_req_t              in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output apa_rsp_t              out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int Slots = 1 << SLOT_BITS;
  localparam int CntW  = SLOT_BITS + 1;
  localparam int WideW = (CntW > TOTAL_W) ? CntW : TOTAL_W;

  logic [ADDR_W-1:0]   subnet_base;
  logic [PREFIX_W-1:0] prefix_length;
  logic [Slots-1:0]    slot_map;
  logic [CntW-1:0]     cnt;
  logic                stage_valid;
  apa_req_t            stage_req;

  logic [Slots-1:0]    slot_map_next;
  logic [CntW-1:0]     cnt_next;
  apa_rsp_t            rsp_next;

  logic                adv;
  logic                in_take;
  logic                cfg_clear;
  logic [ADDR_W-1:0]   host_mask;
  logic [ADDR_W-1:0]   network;
  logic [ADDR_W-1:0]   offset;
  logic                in_window;
  logic [SLOT_BITS-1:0] slot;
  logic                slot_bit;
  logic [Slots-1:0]    alloc_range;
  logic                ff_found;
  logic [SLOT_BITS-1:0] ff_slot;
  logic [WideW-1:0]    cnt_wide;

  assign adv       = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_clear = cfg_we && (cfg_index == CFG_SUBNET_BASE ||
                                cfg_index == CFG_PREFIX_LENGTH);

  assign host_mask = 32'hFFFF_FFFF >> prefix_length;
  assign network   = subnet_base & ~host_mask;
  assign offset    = stage_req.address - network;
  assign in_window = (offset[ADDR_W-1:SLOT_BITS] == '0);
  assign slot      = offset[SLOT_BITS-1:0];
  assign slot_bit  = slot_map[slot];

  always_comb begin
    alloc_range = '0;
    for (int i = 2; i < Slots; i++) begin
      alloc_range[i] = (host_mask[ADDR_W-1:SLOT_BITS] != '0) ||
                       (SLOT_BITS'(i) < host_mask[SLOT_BITS-1:0]);
    end
  end

  apa_first_free #(
    .SLOT_BITS (SLOT_BITS)
  ) u_first_free (
    .free_slots (~slot_map & alloc_range),
    .found      (ff_found),
    .slot       (ff_slot)
  );

  always_comb begin
    slot_map_next            = slot_map;
    cnt_next                 = cnt;
    rsp_next.status          = STAT_OK;
    rsp_next.granted_address = stage_req.address;
    rsp_next.is_used         = 1'b0;
    unique case (stage_req.opcode)
      OP_ALLOC: begin
        if (ff_found) begin
          slot_map_next[ff_slot]   = 1'b1;
          cnt_next                 = cnt + CntW'(1);
          rsp_next.granted_address = network + ADDR_W'(ff_slot);
          rsp_next.is_used         = 1'b1;
        end else begin
          rsp_next.status          = STAT_EXHAUSTED;
          rsp_next.granted_address = '0;
        end
      end
      OP_FREE: begin
        if (!in_window) begin
          rsp_next.status = STAT_OUT_WINDOW;
        end else if (slot_bit) begin
          slot_map_next[slot] = 1'b0;
          cnt_next            = cnt - CntW'(1);
        end else begin
          rsp_next.status = STAT_NOT_ALLOC;
        end
      end
      OP_QUERY: begin
        if (!in_window) begin
          rsp_next.status = STAT_OUT_WINDOW;
        end else begin
          rsp_next.is_used = slot_bit;
          rsp_next.status  = slot_bit ? STAT_OK : STAT_NOT_ALLOC;
        end
      end
      OP_RESERVE: begin
        if (!in_window) begin
          rsp_next.status = STAT_OUT_WINDOW;
        end else begin
          if (!slot_bit) begin
            slot_map_next[slot] = 1'b1;
            cnt_next            = cnt + CntW'(1);
          end
          rsp_next.is_used = 1'b1;
        end
      end
      default: begin
        rsp_next.status = STAT_OK;
      end
    endcase
    cnt_wide            = WideW'(cnt_next);
    rsp_next.used_total = (cnt_wide > WideW'(511)) ? TOTAL_W'(511) : cnt_wide[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_base   <= RST_SUBNET_BASE;
      prefix_length <= RST_PREFIX_LENGTH;
      slot_map      <= Slots'(2);
      cnt           <= CntW'(1);
    end else if (cfg_clear) begin
      if (cfg_index == CFG_SUBNET_BASE) begin
        subnet_base <= cfg_data;
      end else begin
        prefix_length <= cfg_data[PREFIX_W-1:0];
      end
      slot_map <= Slots'(2);
      cnt      <= CntW'(1);
    end else if (adv) begin
      slot_map <= slot_map_next;
      cnt      <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      stage_valid <= in_take || (stage_valid && !adv);
      out_valid   <= adv || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_req <= in_req;
    end
    if (adv) begin
      out_rsp <= rsp_next;
    end
  end

  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    cnt == CntW'($countones(slot_map)))
    else $error("used count differs from marked slots");

  a_cfg_clears_map: assert property (@(posedge clk) disable iff (rst)
    cfg_clear |=> (slot_map == Slots'(2)) && (cnt == CntW'(1)))
    else $error("configuration write did not clear bitmap");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !adv |=> stage_valid && $stable(stage_req))
    else $error("held request changed");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> !in_stall)
    else $error("stall raised with empty request stage");

endmodule

// File: dv/apa_checker.sv
`timescale 1ns / 1ps

module apa_checker
  import apa_pkg::*;
#(
  parameter int SLOT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  apa_req_t              in_req,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  apa_rsp_t              out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int SLOTS = 1 << SLOT_BITS;

  logic [SLOTS-1:0]    slot_used;
  logic [ADDR_W-1:0]   pool_base;
  logic [PREFIX_W-1:0] pool_prefix;
  int unsigned         marked;
  int                  errors = 0;
  apa_rsp_t            answer_q[$];
  apa_rsp_t            want;
  apa_rsp_t            fresh;

  assign fail_count = errors;

  function automatic logic [ADDR_W-1:0] host_bits(input logic [PREFIX_W-1:0] pfx);
    int unsigned p;
    p = (pfx > 32) ? 32 : pfx;
    return {ADDR_W{1'b1}} >> p;
  endfunction

  task automatic clear_pool();
    slot_used    = '0;
    slot_used[1] = 1'b1;
    marked       = 1;
  endtask

  task automatic serve_request(input apa_req_t r, output apa_rsp_t e);
    logic [ADDR_W-1:0] hm;
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] off;
    int unsigned       last;
    int unsigned       s;
    hm                = host_bits(pool_prefix);
    net               = pool_base & ~hm;
    e.status          = STAT_OK;
    e.granted_address = r.address;
    e.is_used         = 1'b0;
    if (r.opcode == OP_ALLOC) begin
      last = SLOTS - 1;
      if (hm < 3) begin
        last = 0;
      end else if (hm - 1 < last) begin
        last = hm - 1;
      end
      s = 2;
      while (s <= last && slot_used[s]) s++;
      if (s <= last) begin
        slot_used[s]      = 1'b1;
        marked++;
        e.granted_address = net + s;
        e.is_used         = 1'b1;
      end else begin
        e.status          = STAT_EXHAUSTED;
        e.granted_address = '0;
      end
    end else begin
      off = r.address - net;
      if (off >= SLOTS) begin
        e.status = STAT_OUT_WINDOW;
      end else begin
        case (r.opcode)
          OP_FREE: begin
            if (slot_used[off]) begin
              slot_used[off] = 1'b0;
              marked--;
            end else begin
              e.status = STAT_NOT_ALLOC;
            end
          end
          OP_QUERY: begin
            e.is_used = slot_used[off];
            if (!slot_used[off]) e.status = STAT_NOT_ALLOC;
          end
          default: begin
            if (!slot_used[off]) begin
              slot_used[off] = 1'b1;
              marked++;
            end
            e.is_used = 1'b1;
          end
        endcase
      end
    end
    e.used_total = (marked > 511) ? '1 : TOTAL_W'(marked);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pool_base   = RST_SUBNET_BASE;
      pool_prefix = RST_PREFIX_LENGTH;
      clear_pool();
      answer_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SUBNET_BASE) begin
          pool_base = cfg_data[ADDR_W-1:0];
          clear_pool();
        end else if (cfg_index == CFG_PREFIX_LENGTH) begin
          pool_prefix = cfg_data[PREFIX_W-1:0];
          clear_pool();
        end
      end
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("response with no request outstanding: %p", out_rsp);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (out_rsp.status !== want.status) begin
            $error("status exp %0d act %0d", want.status, out_rsp.status);
            errors++;
          end
          if (out_rsp.granted_address !== want.granted_address) begin
            $error("granted_address exp %08h act %08h",
                   want.granted_address, out_rsp.granted_address);
            errors++;
          end
          if (out_rsp.is_used !== want.is_used) begin
            $error("is_used exp %0d act %0d", want.is_used, out_rsp.is_used);
            errors++;
          end
          if (out_rsp.used_total !== want.used_total) begin
            $error("used_total exp %0d act %0d", want.used_total, out_rsp.used_total);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        serve_request(in_req, fresh);
        answer_q.push_back(fresh);
      end
    end
    pending <= answer_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import apa_pkg::*;
();

  localparam int SLOT_BITS = 8;
  localparam int SLOTS     = 1 << SLOT_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  apa_req_t              in_req    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  apa_rsp_t              out_rsp;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;

  int          snd_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  logic        hold_toggle   = 1'b0;
  logic        hold_seen     = 1'b0;
  int          hold_left     = 0;
  logic [31:0] cur_base      = RST_SUBNET_BASE;
  logic [5:0]  cur_prefix    = RST_PREFIX_LENGTH;

  address_pool_allocator_top #(.SLOT_BITS(SLOT_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  apa_checker #(.SLOT_BITS(SLOT_BITS)) chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= 60;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  function automatic logic [31:0] pool_net();
    return cur_base & ~(32'hFFFF_FFFF >> ((cur_prefix > 32) ? 32 : cur_prefix));
  endfunction

  task automatic send(input opcode_t op, input logic [31:0] addr);
    apa_req_t r;
    r.opcode  = op;
    r.address = addr;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_SUBNET_BASE) cur_base = data;
    if (idx == CFG_PREFIX_LENGTH) cur_prefix = data[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item(input int alloc_pct);
    opcode_t     op;
    logic [31:0] addr;
    if ($urandom_range(99) < alloc_pct) begin
      op = OP_ALLOC;
    end else begin
      op = opcode_t'($urandom_range(1, 3));
    end
    case ($urandom_range(19))
      0:       addr = $urandom;
      1:       addr = pool_net() - $urandom_range(1, 4);
      2:       addr = pool_net() + SLOTS + $urandom_range(0, 3);
      default: addr = pool_net() + $urandom_range(0, SLOTS - 1);
    endcase
    if (op == OP_ALLOC && $urandom_range(1)) addr = $urandom;
    send(op, addr);
  endtask

  int          seg_prefix[12] = '{24, 26, 0, 16, 28, 31, 25, 40, 24, 30, 22, 32};
  int          seg_alloc[3]   = '{40, 65, 30};
  int          snd_mode[4]    = '{0, 73, 0, 15};
  int          rcv_mode[4]    = '{0, 0, 73, 15};
  logic [31:0] n;
  logic [31:0] seg_base;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_SUBNET_BASE, 32'hC0A8_0137);
    write_reg(CFG_PREFIX_LENGTH, 32'hFFFF_FFD8);
    n = pool_net();
    send(OP_ALLOC, 32'hFFFF_FFFF);
    send(OP_ALLOC, 32'h0);
    send(OP_QUERY, n + 2);
    send(OP_QUERY, n + 4);
    send(OP_FREE, n + 3);
    send(OP_FREE, n + 3);
    send(OP_FREE, n + 1);
    send(OP_QUERY, n + 1);
    send(OP_RESERVE, n + 1);
    send(OP_RESERVE, n + 1);
    send(OP_RESERVE, n + 255);
    send(OP_QUERY, n + 255);
    send(OP_QUERY, n);
    send(OP_RESERVE, n);
    send(OP_QUERY, n + 256);
    send(OP_FREE, n - 1);
    send(OP_RESERVE, 32'h0);
    send(OP_QUERY, 32'hFFFF_FFFF);
    send(OP_ALLOC, 32'h5A5A_A5A5);
    drain();
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    send(OP_QUERY, n + 3);
    drain();
    write_reg(CFG_PREFIX_LENGTH, 31);
    send(OP_ALLOC, 32'h0);
    drain();
    write_reg(CFG_PREFIX_LENGTH, 63);
    send(OP_ALLOC, 32'h0);
    send(OP_QUERY, pool_net());
    drain();
    write_reg(CFG_SUBNET_BASE, $urandom);
    write_reg(CFG_PREFIX_LENGTH, 0);
    send(OP_ALLOC, 32'h0);
    send(OP_QUERY, 32'h0000_00FF);
    drain();
    write_reg(CFG_SUBNET_BASE, 32'h0A00_0004);
    write_reg(CFG_PREFIX_LENGTH, 30);
    send(OP_ALLOC, 32'h0);
    send(OP_ALLOC, 32'h0);
    drain();

    // send random requests behind a long receiver hold, then drain
    write_reg(CFG_PREFIX_LENGTH, 24);
    hold_toggle <= ~hold_toggle;
    repeat (30) random_item(50);
    drain();

    for (int seg = 0; seg < 12; seg++) begin
      case (seg)
        0:       seg_base = 32'hFFFF_FFFF;
        3:       seg_base = 32'h0;
        default: seg_base = $urandom;
      endcase
      write_reg(CFG_SUBNET_BASE, seg_base);
      write_reg(CFG_PREFIX_LENGTH,
                {24'd0, 2'($urandom_range(0, 3)), 6'(seg_prefix[seg])});
      snd_idle_pct  = snd_mode[seg % 4];
      rcv_stall_pct <= rcv_mode[seg % 4];
      repeat (105) random_item(seg_alloc[seg % 3]);
      drain();
    end

    rcv_stall_pct <= 0;
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
